@@ design/dct_4x4_forward_core_assert.svh @@
// ----------------------------------------------------------------------------
// dct_4x4_forward_core assertion macros
// shared property forms for the 4x4 forward dct core
// ----------------------------------------------------------------------------
`ifndef DCT_4X4_FORWARD_CORE_ASSERT_SVH
`define DCT_4X4_FORWARD_CORE_ASSERT_SVH

// same-cycle implication
`define DCT4_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DCT4_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dct4_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct4_pkg
// constants, widths and shared types of the 4x4 forward dct core
// ----------------------------------------------------------------------------
package dct4_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS       = 22;
  localparam int KBITS           = 16;
  localparam int FINAL_SHIFT     = 27;
  localparam int BLOCK_LEN       = 16;

  // cosine constants in q1.15
  localparam logic signed [KBITS-1:0] CK0 = 16'sd23170;
  localparam logic signed [KBITS-1:0] CK1 = 16'sd12540;
  localparam logic signed [KBITS-1:0] CK2 = 16'sd30274;

  typedef enum logic [1:0] {
    K_C0,
    K_C1,
    K_C2,
    K_NC2
  } kmul_e;

  // one beat of work for the shared multiplier
  typedef struct packed {
    logic       valid;
    logic       beat;   // 0: low chunk, 1: high chunk
    logic       clear;  // start a new sum
    logic       last;   // sum complete after this beat
    kmul_e      ksel;
    logic [1:0] tag;    // output slot within the vector
  } mac_ctl_t;

  typedef struct packed {
    logic       done;
    logic [1:0] tag;
  } mac_stat_t;

  // stored element: sample, row result or coefficient
  function automatic int vec_w(int sb);
    return sb + 17;
  endfunction

  // multiplier operand: sum or difference of two butterfly terms, or one term
  function automatic int op_w(int sb);
    return sb + 19;
  endfunction

  function automatic int acc_w(int sb);
    return op_w(sb) + KBITS;
  endfunction

  function automatic logic signed [KBITS-1:0] kval(kmul_e k);
    logic signed [KBITS-1:0] r;
    unique case (k)
      K_C0:    r = CK0;
      K_C1:    r = CK1;
      K_C2:    r = CK2;
      K_NC2:   r = -CK2;
      default: r = CK0;
    endcase
    return r;
  endfunction

endpackage

@@ design/dct4_sample_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct4_sample_if
// sample channel: valid, ready and one signed block sample
// ----------------------------------------------------------------------------
interface dct4_sample_if #(
  parameter int SampleBits = dct4_pkg::SAMPLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

@@ design/dct4_coef_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct4_coef_if
// coefficient channel: valid, ready, coefficient and end-of-block mark
// ----------------------------------------------------------------------------
interface dct4_coef_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dct4_pkg::COEF_BITS-1:0] coefficient;
  logic                                 last_coefficient;

  modport source (output valid, output coefficient, output last_coefficient, input ready);
  modport sink   (input valid, input coefficient, input last_coefficient, output ready);
endinterface

@@ design/dct_4x4_forward_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_4x4_forward_core
// two-dimensional forward 4x4 dct over a stream of block samples
// ----------------------------------------------------------------------------
// The core takes sixteen samples of a 4x4 block in row-major order, one per
// cycle while valid is high, then runs a 4-point butterfly over each row and
// each column through one shared multiply-accumulate unit, halves and rounds
// to 4 fraction bits, and returns sixteen coefficients in row-major order, the
// sixteenth marked last. Each multiply is split into a low and a high operand
// chunk, and each row or column goes through store reads, a butterfly add, the
// multiply beats and a write-back drain. Each coefficient is read from the
// store before it is offered. The core takes no sample from the end of a
// block until its last coefficient has been transferred.
module dct_4x4_forward_core #(
  parameter int SampleBits = dct4_pkg::SAMPLE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dct4_sample_if.sink  sample_i,
  dct4_coef_if.source  coef_o
);
  import dct4_pkg::*;

  localparam int VecW = vec_w(SampleBits);
  localparam int OpW  = op_w(SampleBits);
  localparam int AccW = acc_w(SampleBits);
  localparam int PosW = $clog2(BLOCK_LEN);

  logic                   ram_we;
  logic [PosW-1:0]        ram_waddr;
  logic [VecW-1:0]        ram_wdata;
  logic                   ram_re;
  logic [PosW-1:0]        ram_raddr;
  logic [VecW-1:0]        ram_rdata;
  mac_ctl_t               mac_ctl;
  logic signed [OpW-1:0]  mac_op;
  mac_stat_t              mac_stat;
  logic signed [AccW-1:0] mac_acc;

  dct4_ram #(
    .Width (VecW),
    .Depth (BLOCK_LEN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dct4_mac #(
    .SampleBits (SampleBits)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .op_i   (mac_op),
    .stat_o (mac_stat),
    .acc_o  (mac_acc)
  );

  dct4_ctrl #(
    .SampleBits (SampleBits)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i),
    .coef_o      (coef_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .mac_ctl_o   (mac_ctl),
    .mac_op_o    (mac_op),
    .mac_stat_i  (mac_stat),
    .mac_acc_i   (mac_acc)
  );

endmodule

@@ design/dct4_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct4_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module dct4_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/dct4_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct4_mac
// shared multiply-accumulate: operand times cosine constant in two chunks
// ----------------------------------------------------------------------------
module dct4_mac #(
  parameter int SampleBits = dct4_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  dct4_pkg::mac_ctl_t                          ctl_i,
  input  logic signed [dct4_pkg::op_w(SampleBits)-1:0]  op_i,
  output dct4_pkg::mac_stat_t                         stat_o,
  output logic signed [dct4_pkg::acc_w(SampleBits)-1:0] acc_o
);
  import dct4_pkg::*;

  localparam int OpW  = op_w(SampleBits);
  localparam int AccW = acc_w(SampleBits);
  localparam int LoW  = OpW / 2;
  localparam int ChW  = OpW - LoW + 1;
  localparam int PrW  = ChW + KBITS;

  logic signed [ChW-1:0]  chunk;
  logic signed [PrW-1:0]  prod_d, prod_q;
  logic signed [AccW-1:0] term, acc_d, acc_q;
  mac_ctl_t               ctl1_q;
  mac_stat_t              stat_q;

  // low chunk unsigned, high chunk carries the sign
  assign chunk  = ctl_i.beat ? ChW'(signed'(op_i[OpW-1:LoW]))
                             : ChW'({1'b0, op_i[LoW-1:0]});
  assign prod_d = chunk * kval(ctl_i.ksel);

  assign term  = ctl1_q.beat ? (AccW'(prod_q) <<< LoW) : AccW'(prod_q);
  assign acc_d = (ctl1_q.clear ? '0 : acc_q) + term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      stat_q <= '0;
    end else begin
      ctl1_q      <= ctl_i;
      stat_q.done <= ctl1_q.valid && ctl1_q.last;
      stat_q.tag  <= ctl1_q.tag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      prod_q <= prod_d;
    end
    if (ctl1_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign stat_o = stat_q;
  assign acc_o  = acc_q;

endmodule

@@ design/dct4_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct4_ctrl
// sequencer: block load, row and column butterflies, rounding, emission
// ----------------------------------------------------------------------------
`include "dct_4x4_forward_core_assert.svh"

module dct4_ctrl #(
  parameter int SampleBits = dct4_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  dct4_sample_if.sink                                   sample_i,
  dct4_coef_if.source                                   coef_o,
  output logic                                          ram_we_o,
  output logic [$clog2(dct4_pkg::BLOCK_LEN)-1:0]        ram_waddr_o,
  output logic [dct4_pkg::vec_w(SampleBits)-1:0]        ram_wdata_o,
  output logic                                          ram_re_o,
  output logic [$clog2(dct4_pkg::BLOCK_LEN)-1:0]        ram_raddr_o,
  input  logic [dct4_pkg::vec_w(SampleBits)-1:0]        ram_rdata_i,
  output dct4_pkg::mac_ctl_t                            mac_ctl_o,
  output logic signed [dct4_pkg::op_w(SampleBits)-1:0]  mac_op_o,
  input  dct4_pkg::mac_stat_t                           mac_stat_i,
  input  logic signed [dct4_pkg::acc_w(SampleBits)-1:0] mac_acc_i
);
  import dct4_pkg::*;

  localparam int VecW = vec_w(SampleBits);
  localparam int AW   = VecW + 1;
  localparam int OpW  = op_w(SampleBits);
  localparam int AccW = acc_w(SampleBits);
  localparam int PosW = $clog2(BLOCK_LEN);
  localparam int ShW  = AccW - FINAL_SHIFT;
  localparam int ExtW = (ShW > COEF_BITS) ? ShW : COEF_BITS + 1;

  localparam logic [PosW-1:0] PosLast   = PosW'(BLOCK_LEN - 1);
  localparam logic [3:0]      ReadLast  = 4'd4;
  localparam logic [3:0]      MulLast   = 4'd11;
  localparam logic [3:0]      DrainLast = 4'd2;
  localparam logic [1:0]      VecLast   = 2'd3;

  localparam logic signed [ExtW-1:0] CoefMax = ExtW'((1 << (COEF_BITS - 1)) - 1);
  localparam logic signed [ExtW-1:0] CoefMin = ~CoefMax;
  localparam logic signed [AccW-1:0] RndHalf = AccW'(1) <<< (FINAL_SHIFT - 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_BFLY,
    ST_MUL,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_WT,
    ST_EMIT_OUT
  } state_e;

  typedef enum logic [1:0] {
    OP_SUM,
    OP_DIF,
    OP_A2,
    OP_A3
  } opsel_e;

  state_e                        state_q, state_d;
  logic [PosW-1:0]               pos_q, pos_d;
  logic                          pass_q, pass_d;   // 0: rows, 1: columns
  logic [1:0]                    vec_q, vec_d;
  logic [3:0]                    cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;
  logic                          last_q, last_d;
  logic signed [COEF_BITS-1:0]   coef_q, coef_d;
  mac_ctl_t                      mctl_q, mctl_d;

  logic signed [VecW-1:0]        v_q [4];
  logic signed [AW-1:0]          a_q [4];
  logic signed [OpW-1:0]         op_q, op_d;

  logic [1:0]                    cap_idx;
  logic [2:0]                    step;
  opsel_e                        step_op;
  kmul_e                         step_k;
  logic                          step_first;
  logic                          step_last;
  logic [1:0]                    step_tag;

  logic signed [AccW-1:0]        rnd_sum;
  logic signed [ShW-1:0]         rnd_sh;
  logic signed [ExtW-1:0]        rnd_ext;
  logic signed [ExtW-1:0]        rnd_sat;

  assign cap_idx = 2'(cnt_q - 4'd1);
  assign step    = cnt_q[3:1];

  // butterfly outputs: y0, y2 from one product each, y1 and y3 from two
  always_comb begin
    step_op    = OP_SUM;
    step_k     = K_C0;
    step_first = 1'b1;
    step_last  = 1'b1;
    step_tag   = 2'd0;
    unique case (step)
      3'd0: begin
        step_op = OP_SUM; step_k = K_C0; step_tag = 2'd0;
      end
      3'd1: begin
        step_op = OP_DIF; step_k = K_C0; step_tag = 2'd2;
      end
      3'd2: begin
        step_op = OP_A2; step_k = K_C1; step_last = 1'b0; step_tag = 2'd1;
      end
      3'd3: begin
        step_op = OP_A3; step_k = K_C2; step_first = 1'b0; step_tag = 2'd1;
      end
      3'd4: begin
        step_op = OP_A2; step_k = K_NC2; step_last = 1'b0; step_tag = 2'd3;
      end
      3'd5: begin
        step_op = OP_A3; step_k = K_C1; step_first = 1'b0; step_tag = 2'd3;
      end
      default: begin
        step_op = OP_SUM;
      end
    endcase
  end

  // final rounding to 4 fraction bits, ties upward, then clamp
  always_comb begin
    rnd_sum = mac_acc_i + RndHalf;
    rnd_sh  = ShW'(rnd_sum >>> FINAL_SHIFT);
    rnd_ext = ExtW'(rnd_sh);
    priority if (rnd_ext > CoefMax) begin
      rnd_sat = CoefMax;
    end else if (rnd_ext < CoefMin) begin
      rnd_sat = CoefMin;
    end else begin
      rnd_sat = rnd_ext;
    end
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    pass_d      = pass_q;
    vec_d       = vec_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    last_d      = last_q;
    coef_d      = coef_q;
    mctl_d      = '0;
    op_d        = op_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pos_q;
    ram_wdata_o = VecW'(sample_i.sample);
    ram_re_o    = 1'b0;
    ram_raddr_o = pos_q;

    unique case (state_q)
      ST_LOAD: begin
        if (sample_i.valid) begin
          ram_we_o = 1'b1;
          pos_d    = pos_q + 1'b1;
          if (pos_q == PosLast) begin
            state_d = ST_READ;
            pass_d  = 1'b0;
            vec_d   = '0;
            cnt_d   = '0;
          end
        end
      end
      ST_READ: begin
        if (cnt_q < ReadLast) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = pass_q ? {cnt_q[1:0], vec_q} : {vec_q, cnt_q[1:0]};
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == ReadLast) begin
          state_d = ST_BFLY;
          cnt_d   = '0;
        end
      end
      ST_BFLY: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        unique case (step_op)
          OP_SUM:  op_d = OpW'(a_q[0]) + OpW'(a_q[1]);
          OP_DIF:  op_d = OpW'(a_q[0]) - OpW'(a_q[1]);
          OP_A2:   op_d = OpW'(a_q[2]);
          OP_A3:   op_d = OpW'(a_q[3]);
          default: op_d = OpW'(a_q[0]);
        endcase
        mctl_d.valid = 1'b1;
        mctl_d.beat  = cnt_q[0];
        mctl_d.clear = step_first && !cnt_q[0];
        mctl_d.last  = step_last && cnt_q[0];
        mctl_d.ksel  = step_k;
        mctl_d.tag   = step_tag;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == MulLast) begin
          state_d = ST_DRAIN;
          cnt_d   = '0;
        end
      end
      ST_DRAIN: begin
        // let the multiplier pipeline write back before the next read
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == DrainLast) begin
          cnt_d = '0;
          if (vec_q == VecLast) begin
            vec_d = '0;
            if (!pass_q) begin
              pass_d  = 1'b1;
              state_d = ST_READ;
            end else begin
              pos_d   = '0;
              state_d = ST_EMIT_RD;
            end
          end else begin
            vec_d   = vec_q + 2'd1;
            state_d = ST_READ;
          end
        end
      end
      ST_EMIT_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = pos_q;
        state_d     = ST_EMIT_WT;
      end
      ST_EMIT_WT: begin
        out_valid_d = 1'b1;
        coef_d      = signed'(ram_rdata_i[COEF_BITS-1:0]);
        last_d      = (pos_q == PosLast);
        state_d     = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (coef_o.ready) begin
          out_valid_d = 1'b0;
          pos_d       = pos_q + 1'b1;
          if (last_q) begin
            state_d = ST_LOAD;
          end else begin
            // fetch the next coefficient on the transfer cycle
            ram_re_o    = 1'b1;
            ram_raddr_o = pos_q + 1'b1;
            state_d     = ST_EMIT_WT;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    // write-back: row results in place, coefficients over their column
    if (mac_stat_i.done) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = pass_q ? {mac_stat_i.tag, vec_q} : {vec_q, mac_stat_i.tag};
      ram_wdata_o = pass_q ? VecW'(COEF_BITS'(rnd_sat)) : VecW'(mac_acc_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      pos_q       <= '0;
      pass_q      <= 1'b0;
      vec_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      coef_q      <= '0;
      mctl_q      <= '0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      pass_q      <= pass_d;
      vec_q       <= vec_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      coef_q      <= coef_d;
      mctl_q      <= mctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ && cnt_q != '0) begin
      v_q[cap_idx] <= signed'(ram_rdata_i);
    end
    if (state_q == ST_BFLY) begin
      a_q[0] <= AW'(v_q[0]) + AW'(v_q[3]);
      a_q[3] <= AW'(v_q[0]) - AW'(v_q[3]);
      a_q[1] <= AW'(v_q[1]) + AW'(v_q[2]);
      a_q[2] <= AW'(v_q[1]) - AW'(v_q[2]);
    end
    op_q <= op_d;
  end

  assign sample_i.ready         = (state_q == ST_LOAD);
  assign coef_o.valid           = out_valid_q;
  assign coef_o.coefficient     = coef_q;
  assign coef_o.last_coefficient = last_q;
  assign mac_ctl_o              = mctl_q;
  assign mac_op_o               = op_q;

  `DCT4_ASSERT_IMP(a_wb_in_pass, clk_i, rst_ni, mac_stat_i.done, (state_q == ST_MUL) || (state_q == ST_DRAIN), "write-back outside a transform pass")
  `DCT4_ASSERT_IMP(a_load_quiet, clk_i, rst_ni, state_q == ST_LOAD, !mctl_q.valid && !out_valid_q && !mac_stat_i.done, "work pending while loading")
  `DCT4_ASSERT_NXT(a_last_to_load, clk_i, rst_ni, coef_o.valid && coef_o.ready && coef_o.last_coefficient, state_q == ST_LOAD, "no return to load after block end")
  `DCT4_ASSERT_NXT(a_next_fetch, clk_i, rst_ni, coef_o.valid && coef_o.ready && !coef_o.last_coefficient, state_q == ST_EMIT_WT, "next coefficient not fetched")

endmodule
